// ===== rtl/ktwa_pkg.sv =====
// ----------------------------------------------------------------------------
// ktwa_pkg
// Shared types and constants of the keyed tumbling window aggregator.
// ----------------------------------------------------------------------------
package ktwa_pkg;

   localparam int unsigned KeyCountDefault = 1024;
   localparam int unsigned KeyW = 10;
   localparam int unsigned TsW = 63;
   localparam int unsigned ValW = 64;
   localparam int unsigned CntW = 32;
   localparam int unsigned PosW = 64;
   localparam int unsigned CsrIdxW = 2;
   localparam int unsigned CsrDataW = 32;

   localparam logic [CsrIdxW-1:0] CSR_WINDOW_MODE = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_WINDOW_SIZE = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_AGGR_FUNC = 2'd2;

   localparam logic [2:0] FN_SUM = 3'd0;
   localparam logic [2:0] FN_MIN = 3'd1;
   localparam logic [2:0] FN_MAX = 3'd2;
   localparam logic [2:0] FN_COUNT = 3'd3;

   localparam logic [TsW-1:0] TS_MAX = {TsW{1'b1}};
   localparam logic [CntW-1:0] CNT_MAX = {CntW{1'b1}};

   // One bucket as held in the state memory
   typedef struct packed {
      logic [TsW-1:0]  begin_t;
      logic [TsW-1:0]  end_t;
      logic [CntW-1:0] rows;
      logic [CntW-1:0] nn;
      logic [ValW-1:0] rv;
      logic [PosW-1:0] pos;
   } bucket_type;

   // One result word
   typedef struct packed {
      logic [KeyW-1:0] key;
      logic [TsW-1:0]  begin_t;
      logic [TsW-1:0]  end_t;
      logic [CntW-1:0] rows;
      logic [ValW-1:0] agg;
      logic [CntW-1:0] nn;
      logic            agg_null;
      logic [PosW-1:0] pos;
      logic            late;
      logic            last;
   } result_type;

   function automatic logic [TsW-1:0] ts_add(input logic [TsW-1:0] a,
                                              input logic [CntW-1:0] b);
      logic [TsW:0] s;
      s = {1'b0, a} + {{(TsW-CntW+1){1'b0}}, b};
      return s[TsW] ? TS_MAX : s[TsW-1:0];
   endfunction

   function automatic logic [CntW-1:0] cnt_inc(input logic [CntW-1:0] c);
      return (c == CNT_MAX) ? c : c + 1'b1;
   endfunction

endpackage

// ===== rtl/keyed_tumbling_window_aggregator.sv =====
// ----------------------------------------------------------------------------
// Results: those of a word enter the output queue at the edge after it is accepted.
// Throughput: one word per cycle while the output queue is empty; a word in
// stage 2 reserves two queue slots, so any result still waiting holds the input.
// Reset: registers take their reset values, then a sweep over all KEY_COUNT keys
// clears the open flags with req_ready low; bucket storage needs no clearing.
// ----------------------------------------------------------------------------
// keyed_tumbling_window_aggregator
// Per-key tumbling bucket aggregation over a row stream.
// ----------------------------------------------------------------------------
module keyed_tumbling_window_aggregator
   import ktwa_pkg::*;
#(
   parameter int unsigned KEY_COUNT = KeyCountDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [KeyW-1:0]      req_key_index,
   input  logic [TsW-1:0]       req_timestamp,
   input  logic signed [ValW-1:0] req_value,
   input  logic                 req_value_is_null,
   input  logic [PosW-1:0]      req_log_offset,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [KeyW-1:0]      rsp_out_key_index,
   output logic [TsW-1:0]       rsp_bucket_begin,
   output logic [TsW-1:0]       rsp_bucket_end,
   output logic [CntW-1:0]      rsp_row_count,
   output logic signed [ValW-1:0] rsp_aggregate,
   output logic [CntW-1:0]      rsp_non_null_count,
   output logic                 rsp_aggregate_is_null,
   output logic [PosW-1:0]      rsp_out_log_offset,
   output logic                 rsp_late,
   output logic                 rsp_last,
   input  logic                 csr_write_enable,
   input  logic [CsrIdxW-1:0]   csr_index,
   input  logic [CsrDataW-1:0]  csr_write_data
);

   localparam int unsigned AddrW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam int unsigned QDepth = 4;
   localparam int unsigned QPtrW = 2;

   logic            mode_ff;
   logic [CntW-1:0] size_ff;
   logic [2:0]      func_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         size_ff <= CntW'(1000);
         func_ff <= FN_SUM;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_WINDOW_MODE: mode_ff <= csr_write_data[0];
            CSR_WINDOW_SIZE: size_ff <= csr_write_data;
            CSR_AGGR_FUNC:   func_ff <= csr_write_data[2:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------- storage
   bucket_type      mem [KEY_COUNT];
   logic            open_mem [KEY_COUNT];
   bucket_type      rd_ff;
   logic            clr_busy_ff;
   logic [AddrW-1:0] clr_addr_ff;

   // ------------------------------------------------------------- stage 1
   logic            s1_valid_ff;
   logic [AddrW-1:0] s1_addr_ff;
   logic [TsW-1:0]  s1_ts_ff;
   logic [ValW-1:0] s1_val_ff;
   logic            s1_null_ff;
   logic [PosW-1:0] s1_pos_ff;
   logic            s1_open_ff;

   // write-back of stage 2, used for forwarding
   logic            wb_en;
   bucket_type      wb_data;

   logic            in_range;
   logic            accept;
   logic [AddrW-1:0] req_addr;
   logic [QPtrW:0]  q_count_ff;
   logic            q_room;

   // sweep the open flags after reset, one key per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_busy_ff <= (clr_addr_ff != AddrW'(KEY_COUNT - 1));
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   assign in_range = ({{(32-KeyW){1'b0}}, req_key_index} < KEY_COUNT);
   assign req_addr = AddrW'(req_key_index);
   // two free slots before each word enters: the word ahead may still add two
   assign q_room = (q_count_ff + (s1_valid_ff ? 3'd2 : 3'd0)) <= 3'(QDepth - 2);
   assign req_ready = q_room && !clr_busy_ff;
   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept && in_range;
      end
      s1_addr_ff <= req_addr;
      s1_ts_ff <= req_timestamp;
      s1_val_ff <= req_value;
      s1_null_ff <= req_value_is_null;
      s1_pos_ff <= req_log_offset;
      // forward the bucket that stage 2 writes this cycle
      if (wb_en && s1_addr_ff == req_addr) begin
         rd_ff <= wb_data;
         s1_open_ff <= 1'b1;
      end else begin
         rd_ff <= mem[req_addr];
         s1_open_ff <= open_mem[req_addr];
      end
   end

   // ------------------------------------------------------------- stage 2
   bucket_type      cur;
   bucket_type      nxt;
   logic [CntW-1:0] esize;
   logic [CntW-1:0] esize_m1;
   logic            filled;
   logic            is_late;
   logic [TsW-1:0]  nb;
   logic [ValW-1:0] late_rv;
   logic [CntW-1:0] late_nn;
   result_type      res_a;
   result_type      res_b;
   logic            emit_a;
   logic            emit_b;

   function automatic logic [ValW-1:0] fold_rv(input logic [2:0] fn,
                                              input logic [ValW-1:0] rv,
                                              input logic [CntW-1:0] nn,
                                              input logic [ValW-1:0] v);
      logic [ValW-1:0] r;
      r = rv;
      case (fn)
         FN_MIN: if (nn == '0 || $signed(v) < $signed(rv)) r = v;
         FN_MAX: if (nn == '0 || $signed(rv) < $signed(v)) r = v;
         FN_COUNT: r = rv;
         default: r = rv + v;
      endcase
      return r;
   endfunction

   always_comb begin
      esize = (size_ff == '0) ? CntW'(1) : size_ff;
      esize_m1 = esize - 1'b1;
      cur = rd_ff;
      if (!s1_open_ff) begin
         cur.begin_t = s1_ts_ff;
         cur.end_t = mode_ff ? s1_ts_ff : ts_add(s1_ts_ff, esize_m1);
         cur.rows = '0;
         cur.nn = '0;
         cur.rv = '0;
         cur.pos = '0;
      end
      filled = mode_ff ? (cur.rows >= esize) : (s1_ts_ff > cur.end_t);
      nb = ts_add(cur.end_t, CntW'(1));

      res_a.key = KeyW'(s1_addr_ff);
      res_a.begin_t = cur.begin_t;
      res_a.end_t = cur.end_t;
      res_a.rows = cur.rows;
      res_a.agg = (func_ff == FN_COUNT) ? {{(ValW-CntW){1'b0}}, cur.nn} : cur.rv;
      res_a.nn = cur.nn;
      res_a.agg_null = (func_ff == FN_MIN || func_ff == FN_MAX) && cur.nn == '0;
      res_a.pos = cur.pos;
      res_a.late = 1'b0;

      nxt = cur;
      if (filled) begin
         nxt.begin_t = nb;
         nxt.end_t = mode_ff ? nb : ts_add(nb, esize_m1);
         nxt.rows = '0;
         nxt.nn = '0;
         nxt.rv = '0;
         nxt.pos = '0;
      end
      is_late = s1_ts_ff < nxt.begin_t;

      late_nn = s1_null_ff ? '0 : CntW'(1);
      late_rv = s1_null_ff ? '0 : fold_rv(func_ff, '0, '0, s1_val_ff);
      res_b.key = KeyW'(s1_addr_ff);
      res_b.begin_t = s1_ts_ff;
      res_b.end_t = s1_ts_ff;
      res_b.rows = CntW'(1);
      res_b.agg = (func_ff == FN_COUNT) ? {{(ValW-CntW){1'b0}}, late_nn} : late_rv;
      res_b.nn = late_nn;
      res_b.agg_null = (func_ff == FN_MIN || func_ff == FN_MAX) && s1_null_ff;
      res_b.pos = s1_pos_ff;
      res_b.late = 1'b1;
      res_b.last = 1'b1;

      if (!is_late) begin
         nxt.rows = cnt_inc(nxt.rows);
         nxt.pos = s1_pos_ff;
         if (mode_ff) nxt.end_t = s1_ts_ff;
         if (!s1_null_ff) begin
            nxt.rv = fold_rv(func_ff, nxt.rv, nxt.nn, s1_val_ff);
            nxt.nn = cnt_inc(nxt.nn);
         end
      end
      res_a.last = !is_late;

      emit_a = s1_valid_ff && filled;
      emit_b = s1_valid_ff && is_late;
      wb_en = s1_valid_ff;
      wb_data = nxt;
   end

   always_ff @(posedge clock) begin
      if (wb_en) mem[s1_addr_ff] <= wb_data;
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         open_mem[clr_addr_ff] <= 1'b0;
      end else if (wb_en) begin
         open_mem[s1_addr_ff] <= 1'b1;
      end
   end

   // ------------------------------------------------------------- output queue
   result_type      q_ff [QDepth];
   logic [QPtrW-1:0] q_wr_ff;
   logic [QPtrW-1:0] q_rd_ff;
   logic            pop;
   logic [1:0]      push_n;
   result_type      q_head;

   assign pop = rsp_valid && rsp_ready;
   assign push_n = {1'b0, emit_a} + {1'b0, emit_b};

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff <= '0;
         q_rd_ff <= '0;
         q_count_ff <= '0;
      end else begin
         q_wr_ff <= q_wr_ff + QPtrW'(push_n);
         q_rd_ff <= q_rd_ff + QPtrW'(pop);
         q_count_ff <= q_count_ff + (QPtrW+1)'(push_n) - (QPtrW+1)'(pop);
      end
      if (emit_a) q_ff[q_wr_ff] <= res_a;
      if (emit_b) q_ff[q_wr_ff + QPtrW'(emit_a)] <= res_b;
   end

   assign q_head = q_ff[q_rd_ff];
   assign rsp_valid = (q_count_ff != '0);
   assign rsp_out_key_index = q_head.key;
   assign rsp_bucket_begin = q_head.begin_t;
   assign rsp_bucket_end = q_head.end_t;
   assign rsp_row_count = q_head.rows;
   assign rsp_aggregate = q_head.agg;
   assign rsp_non_null_count = q_head.nn;
   assign rsp_aggregate_is_null = q_head.agg_null;
   assign rsp_out_log_offset = q_head.pos;
   assign rsp_late = q_head.late;
   assign rsp_last = q_head.last;

   // ------------------------------------------------------------- checks
   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= (QPtrW+1)'(QDepth))
      else $error("output queue overflow");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(q_head)))
      else $error("result word changed while waiting");

   a_clear_block: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_ready)
      else $error("input taken during open flag sweep");

endmodule

// ===== bench/tb_keyed_tumbling_window_aggregator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyed_tumbling_window_aggregator
// Drives row words into the aggregator under time and row-count buckets and
// every function code, with random idling on both sides. A scoreboard models
// the per-key buckets and checks every emitted bucket field by field, in order.
// ----------------------------------------------------------------------------
module tb_keyed_tumbling_window_aggregator;
   import ktwa_pkg::*;

   localparam logic [2:0] FN_AVG = 3'd4;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int NKEYS = 1024;

   // ------------------------------------------------------------------------
   class window_scoreboard;
      logic            mode;
      logic [31:0]     size;
      logic [2:0]      func;
      bit              open_q[NKEYS];
      logic [TsW-1:0]  begin_q[NKEYS];
      logic [TsW-1:0]  end_q[NKEYS];
      logic [CntW-1:0] rows_q[NKEYS];
      logic [CntW-1:0] nn_q[NKEYS];
      logic [ValW-1:0] rv_q[NKEYS];
      logic [PosW-1:0] pos_q[NKEYS];
      result_type      bucket_q[$];
      int              errors;
      int              checked;
      int              late_seen;

      function new();
         mode = 1'b0;
         size = 32'd1000;
         func = FN_SUM;
         foreach (open_q[i]) open_q[i] = 1'b0;
         errors = 0;
         checked = 0;
         late_seen = 0;
      endfunction

      function void set_reg(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] data);
         case (idx)
            CSR_WINDOW_MODE: mode = data[0];
            CSR_WINDOW_SIZE: size = data;
            CSR_AGGR_FUNC:   func = data[2:0];
            default: ;
         endcase
      endfunction

      function logic [TsW-1:0] sat_add(logic [TsW-1:0] a, logic [32:0] b);
         logic [TsW:0] s;
         s = {1'b0, a} + {{(TsW-32){1'b0}}, b};
         return s[TsW] ? TS_MAX : s[TsW-1:0];
      endfunction

      function logic [CntW-1:0] sat_inc(logic [CntW-1:0] c);
         return (c == CNT_MAX) ? c : c + 1'b1;
      endfunction

      function void fold(ref logic [ValW-1:0] rv, ref logic [CntW-1:0] nn,
                         input logic signed [ValW-1:0] v, input logic nul);
         if (nul) return;
         case (func)
            FN_MIN:   if (nn == 0 || v < $signed(rv)) rv = v;
            FN_MAX:   if (nn == 0 || $signed(rv) < v) rv = v;
            FN_COUNT: ;
            default:  rv = rv + v;
         endcase
         nn = sat_inc(nn);
      endfunction

      function void push_bucket(logic [KeyW-1:0] k, logic [TsW-1:0] b,
                                logic [TsW-1:0] e, logic [CntW-1:0] rows,
                                logic [CntW-1:0] nn, logic [ValW-1:0] rv,
                                logic [PosW-1:0] pos, logic is_late);
         result_type r;
         r.key = k;
         r.begin_t = b;
         r.end_t = e;
         r.rows = rows;
         r.agg = (func == FN_COUNT) ? {32'd0, nn} : rv;
         r.nn = nn;
         r.agg_null = (func == FN_MIN || func == FN_MAX) && nn == 0;
         r.pos = pos;
         r.late = is_late;
         r.last = 1'b0;
         bucket_q.push_back(r);
      endfunction

      function void clear_key(logic [KeyW-1:0] k);
         rows_q[k] = '0;
         nn_q[k] = '0;
         rv_q[k] = '0;
         pos_q[k] = '0;
      endfunction

      // Advance the bucket of one key by an accepted row word
      function void note_word(logic [KeyW-1:0] k, logic [TsW-1:0] ts,
                              logic signed [ValW-1:0] v, logic nul,
                              logic [PosW-1:0] off);
         logic [32:0]     eff;
         logic [TsW-1:0]  nb;
         logic [ValW-1:0] lrv;
         logic [CntW-1:0] lnn;
         bit              filled;
         int              n;
         n = 0;
         eff = (size == 0) ? 33'd1 : {1'b0, size};
         if (!open_q[k]) begin
            open_q[k] = 1'b1;
            begin_q[k] = ts;
            end_q[k] = (mode == 1'b0) ? sat_add(ts, eff - 1) : ts;
            clear_key(k);
         end
         filled = (mode == 1'b0) ? (ts > end_q[k]) : ({1'b0, rows_q[k]} >= eff);
         if (filled) begin
            push_bucket(k, begin_q[k], end_q[k], rows_q[k], nn_q[k], rv_q[k],
                        pos_q[k], 1'b0);
            n++;
            nb = sat_add(end_q[k], 33'd1);
            begin_q[k] = nb;
            end_q[k] = (mode == 1'b0) ? sat_add(nb, eff - 1) : nb;
            clear_key(k);
         end
         if (ts < begin_q[k]) begin
            lrv = '0;
            lnn = '0;
            fold(lrv, lnn, v, nul);
            push_bucket(k, ts, ts, 32'd1, lnn, lrv, off, 1'b1);
            n++;
         end else begin
            rows_q[k] = sat_inc(rows_q[k]);
            pos_q[k] = off;
            if (mode == 1'b1) end_q[k] = ts;
            fold(rv_q[k], nn_q[k], v, nul);
         end
         if (n > 0) bucket_q[bucket_q.size()-1].last = 1'b1;
      endfunction

      task report(string what, logic [127:0] got, logic [127:0] want);
         $display("mismatch %0s: got %0h want %0h", what, got, want);
         errors++;
      endtask

      task check_bucket(result_type got);
         result_type w;
         checked++;
         if (got.late) late_seen++;
         if (bucket_q.size() == 0) begin
            report("unexpected word", 128'(got.key), 128'(0));
            return;
         end
         w = bucket_q.pop_front();
         if (got.key != w.key) report("key", 128'(got.key), 128'(w.key));
         if (got.begin_t != w.begin_t)
            report("bucket_begin", 128'(got.begin_t), 128'(w.begin_t));
         if (got.end_t != w.end_t)
            report("bucket_end", 128'(got.end_t), 128'(w.end_t));
         if (got.rows != w.rows) report("row_count", 128'(got.rows), 128'(w.rows));
         if (got.agg != w.agg) report("aggregate", 128'(got.agg), 128'(w.agg));
         if (got.nn != w.nn) report("non_null_count", 128'(got.nn), 128'(w.nn));
         if (got.agg_null != w.agg_null)
            report("aggregate_is_null", 128'(got.agg_null), 128'(w.agg_null));
         if (got.pos != w.pos) report("log_offset", 128'(got.pos), 128'(w.pos));
         if (got.late != w.late) report("late", 128'(got.late), 128'(w.late));
         if (got.last != w.last) report("last", 128'(got.last), 128'(w.last));
      endtask
   endclass

   // ------------------------------------------------------------------------
   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [KeyW-1:0]        req_key_index;
   logic [TsW-1:0]         req_timestamp;
   logic signed [ValW-1:0] req_value;
   logic                   req_value_is_null;
   logic [PosW-1:0]        req_log_offset;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [KeyW-1:0]        rsp_out_key_index;
   logic [TsW-1:0]         rsp_bucket_begin;
   logic [TsW-1:0]         rsp_bucket_end;
   logic [CntW-1:0]        rsp_row_count;
   logic signed [ValW-1:0] rsp_aggregate;
   logic [CntW-1:0]        rsp_non_null_count;
   logic                   rsp_aggregate_is_null;
   logic [PosW-1:0]        rsp_out_log_offset;
   logic                   rsp_late;
   logic                   rsp_last;
   logic                   csr_write_enable;
   logic [CsrIdxW-1:0]     csr_index;
   logic [CsrDataW-1:0]    csr_write_data;

   keyed_tumbling_window_aggregator dut (.*);

   window_scoreboard sb = new();
   int  words_in;
   int  phases_run;
   bit  req_stall;
   bit  rsp_stall;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_key_index = '0;
      req_timestamp = '0;
      req_value = '0;
      req_value_is_null = 1'b0;
      req_log_offset = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Watchdog: cycles with no accepted word on either channel
   int idle_cycles;
   int last_in, last_out;
   always @(posedge clock) begin
      if (reset || words_in != last_in || sb.checked != last_out) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired, %0d buckets outstanding", sb.bucket_q.size());
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      last_in <= words_in;
      last_out <= sb.checked;
   end

   // Result side: random stalls, capture at the falling edge
   initial begin
      int gap;
      int cnt;
      result_type got;
      cnt = 0;
      rsp_stall = 1'b1;
      @(negedge reset);
      forever begin
         if (cnt % 40 == 0) rsp_stall = ($urandom % 3) != 0;
         cnt++;
         gap = rsp_stall ? $urandom_range(0, 17) : 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
         while (!rsp_valid) @(negedge clock);
         got.key = rsp_out_key_index;
         got.begin_t = rsp_bucket_begin;
         got.end_t = rsp_bucket_end;
         got.rows = rsp_row_count;
         got.agg = rsp_aggregate;
         got.nn = rsp_non_null_count;
         got.agg_null = rsp_aggregate_is_null;
         got.pos = rsp_out_log_offset;
         got.late = rsp_late;
         got.last = rsp_last;
         sb.check_bucket(got);
         @(posedge clock);
      end
   end

   task automatic send_word(logic [KeyW-1:0] k, logic [TsW-1:0] ts,
                            logic signed [ValW-1:0] v, logic nul,
                            logic [PosW-1:0] off);
      int gap;
      if (words_in % 50 == 0) req_stall = ($urandom % 3) != 0;
      gap = req_stall ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_key_index <= k;
      req_timestamp <= ts;
      req_value <= v;
      req_value_is_null <= nul;
      req_log_offset <= off;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      sb.note_word(k, ts, v, nul, off);
      @(posedge clock);
      words_in++;
   endtask

   task automatic csr_write(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   // Drain, let words with no bucket clear the pipeline, then reprogram
   task automatic configure(logic mode, logic [31:0] size, logic [2:0] func);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.bucket_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write(CSR_WINDOW_MODE, {31'd0, mode});
      csr_write(CSR_WINDOW_SIZE, size);
      csr_write(CSR_AGGR_FUNC, {29'd0, func});
      csr_write_enable <= 1'b0;
      @(posedge clock);
      phases_run++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic signed [ValW-1:0] pick_value();
      case ($urandom % 6)
         0: return 64'sh7FFF_FFFF_FFFF_FFFF;
         1: return 64'sh8000_0000_0000_0000;
         2: return $signed(64'($urandom_range(0, 200))) - 64'sd100;
         default: return rand64();
      endcase
   endfunction

   task automatic run_random(int count, logic mode, logic [31:0] size);
      logic [TsW-1:0]  tcur;
      logic [TsW-1:0]  ts;
      logic [KeyW-1:0] pool[6];
      logic [KeyW-1:0] k;
      logic [31:0]     step;
      int              r;
      step = (mode == 1'b0 && size != 0 && size < 200) ? size / 3 + 1 : 40;
      tcur = ($urandom % 4 == 0) ? TS_MAX - 63'($urandom_range(0, 3000)) :
             (($urandom % 2) ? 63'(rand64() >> 1) : 63'($urandom_range(0, 5000)));
      foreach (pool[i]) pool[i] = KeyW'($urandom_range(0, NKEYS - 1));
      for (int i = 0; i < count; i++) begin
         r = $urandom % 100;
         k = (r < 90) ? pool[$urandom % 6] : KeyW'($urandom);
         tcur = tcur + 63'($urandom_range(0, step));
         ts = tcur;
         if (r >= 90 && r < 95) begin
            // drop well behind the open bucket
            ts = tcur - 63'($urandom_range(1, 4 * step));
         end else if (r >= 95 && r < 97) begin
            tcur = tcur + 63'(step) * 20;
            ts = tcur;
         end else if (r == 97) begin
            ts = 63'(rand64() >> 1);
         end
         send_word(k, ts, pick_value(), ($urandom % 5) == 0, rand64());
      end
   endtask

   initial begin
      logic [2:0]  func;
      logic [31:0] size;
      logic        mode;
      words_in = 0;
      phases_run = 0;
      req_stall = 1'b1;
      @(negedge reset);
      @(posedge clock);

      // Reset settings: time buckets of 1000, sum
      send_word(0, 0, 64'sh7FFF_FFFF_FFFF_FFFF, 1'b0, '0);
      send_word(0, 999, 64'sd1, 1'b0, '1);
      send_word(0, 1000, 64'sh8000_0000_0000_0000, 1'b0, 64'd5);
      send_word(0, 5000, 64'sd7, 1'b1, 64'd6);
      send_word(0, 10, -64'sd3, 1'b0, 64'd7);
      send_word(0, 10, -64'sd3, 1'b1, 64'd8);
      send_word(0, 6000, 64'sd2, 1'b0, 64'd9);
      send_word(1023, TS_MAX - 5, -64'sd1, 1'b0, '1);
      send_word(1023, TS_MAX, 64'sd4, 1'b0, 64'd10);
      send_word(1023, 0, 64'sd9, 1'b1, 64'd11);
      send_word(1023, TS_MAX, 64'sd4, 1'b0, 64'd12);
      send_word(512, 63'h2AAA_AAAA_AAAA_AAAA, 64'sh5555_5555_5555_5555, 1'b0, 64'hAAAA);

      // Row buckets with min, then time buckets with max, with nulls and late rows
      configure(1'b1, 32'd2, FN_MIN);
      send_word(7, 100, 64'sd5, 1'b1, 64'd1);
      send_word(7, 101, 64'sd5, 1'b1, 64'd2);
      send_word(7, 102, -64'sd8, 1'b0, 64'd3);
      send_word(7, 50, 64'sd1, 1'b1, 64'd4);
      send_word(7, 103, 64'sd3, 1'b0, 64'd5);
      send_word(7, 104, 64'sd0, 1'b0, 64'd6);
      configure(1'b0, 32'd0, FN_MAX);
      send_word(7, 200, 64'sd1, 1'b0, 64'd7);
      send_word(7, 200, 64'sd2, 1'b0, 64'd8);
      send_word(7, 201, 64'sd3, 1'b1, 64'd9);
      send_word(7, 150, 64'sd3, 1'b1, 64'd10);

      for (int ph = 0; ph < 14; ph++) begin
         mode = ph[0];
         func = ph[2:0] ^ {2'b00, ph[3]};
         case (ph)
            2: size = 32'hFFFF_FFFF;
            3: size = 32'd1;
            4: size = 32'd0;
            default: size = mode ? $urandom_range(1, 6) : $urandom_range(2, 60);
         endcase
         configure(mode, size, func);
         run_random(100, mode, size);
      end
      configure(1'b0, 32'd1000, FN_AVG);
      run_random(20, 1'b0, 32'd1000);

      req_valid <= 1'b0;
      while (sb.bucket_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("%0d row words over %0d settings, %0d buckets checked (%0d late)",
               words_in, phases_run, sb.checked, sb.late_seen);
      if (sb.errors == 0 && sb.bucket_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches, %0d buckets missing", sb.errors, sb.bucket_q.size());
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/ktwa_pkg.sv
rtl/keyed_tumbling_window_aggregator.sv
bench/tb_keyed_tumbling_window_aggregator.sv
